@@ hdl/cmap_pkg.sv @@
// Package for the colour map lookup: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
package cmap_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW      = $clog2(TableDepth);
    localparam int CntW      = IdxW + 1;
    localparam int FracBits  = 16;
    localparam int KeyW      = 32;
    localparam int ChanW     = 16;
    localparam int ColW      = 3 * ChanW;

    localparam logic CmdLoad   = 1'b0;
    localparam logic CmdLookup = 1'b1;

    localparam logic [0:0] RegEntries = 1'b0;
    localparam logic [0:0] RegNearest = 1'b1;

    // One step of the restoring divider handed between cells.
    typedef struct packed {
        logic                  vld;
        logic [KeyW:0]         rem;
        logic [FracBits:0]     quo;
    } div_step_t;
endpackage

@@ hdl/colour_map_interpolating_lookup.sv @@
// Top level of the colour map lookup: table memory, search sequencer,
// interpolation and output register. Depends on cmap_pkg and cmap_divider.
//
// Usage: items enter on s_valid/s_ready. A load item (cmd 0) writes one
// table entry and gives no result. A lookup item (cmd 1) gives one colour
// on m_valid/m_ready. Configuration registers are written on cfg_valid/
// cfg_ready with cfg_index 0 (entries in use) and 1 (nearest threshold).
// One item is worked on at a time and s_ready is high only when idle.
// A load is written from idle, so loads can follow back to back. A
// lookup that clamps to the first key goes from the first end key check
// to the output, and one that clamps to the last key from the second. A
// bracketed lookup runs both end key checks, up to 8 binary search steps
// of a midpoint read and compare, the reads of the bracketing pair and the
// fraction pick, the divider chain (skipped when the fraction is 0 or 1)
// and the blend, sum and output states. The next item is accepted only
// once the sequencer is back in idle. The result sits in an output
// register; while the receiver stalls, the next item is accepted and
// worked on, but its result waits until the register is free. Reset
// clears control state and sets the registers to 1 and 100; the table
// is undefined until written.
module colour_map_interpolating_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_entry_index,
    input  logic signed [31:0] s_entry_key,
    input  logic [15:0] s_red,
    input  logic [15:0] s_green,
    input  logic [15:0] s_blue,
    input  logic signed [31:0] s_query_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_red,
    output logic [15:0] m_out_green,
    output logic [15:0] m_out_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    import cmap_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CK0   = 13'b0000000000010,
        ST_CKN   = 13'b0000000000100,
        ST_SRCH  = 13'b0000000001000,
        ST_SCMP  = 13'b0000000010000,
        ST_RDLO  = 13'b0000000100000,
        ST_RDHI  = 13'b0000001000000,
        ST_KHI   = 13'b0000010000000,
        ST_FRAC  = 13'b0000100000000,
        ST_DIV   = 13'b0001000000000,
        ST_MUL   = 13'b0010000000000,
        ST_SUM   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Table memory, one read port with registered data.
    logic [KeyW+ColW-1:0] mem [0:TableDepth-1];
    logic [KeyW+ColW-1:0] rd_data_reg;
    logic [IdxW-1:0]      rd_addr;
    logic                 wr_en;

    logic [CntW-1:0] entries_reg, nearest_reg, n_reg;
    logic signed [KeyW-1:0] query_reg, klo_reg, khi_reg;
    logic [IdxW-1:0] lo_reg, hi_reg, mid;
    logic [ColW-1:0] clo_reg, chi_reg, res_reg;
    logic [FracBits:0] frac_reg;
    logic            div_start_reg;
    logic            div_done;
    logic [FracBits:0] div_quo;
    logic [KeyW:0]   num_w, den_w;
    logic            skip_div;
    logic [ChanW+FracBits:0] prod_lo_reg [0:2];
    logic [ChanW+FracBits:0] prod_hi_reg [0:2];
    logic            m_valid_reg;
    logic [ColW-1:0] m_col_reg;
    logic signed [KeyW-1:0] rd_key;
    logic [ColW-1:0] rd_col;
    logic [CntW-1:0] n_clamped;

    assign rd_key = rd_data_reg[KeyW+ColW-1:ColW];
    assign rd_col = rd_data_reg[ColW-1:0];
    assign mid    = IdxW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign wr_en  = s_valid && s_ready && (s_cmd == CmdLoad);

    always_comb begin
        if (entries_reg == '0) begin
            n_clamped = CntW'(1);
        end else if (entries_reg > CntW'(TableDepth)) begin
            n_clamped = CntW'(TableDepth);
        end else begin
            n_clamped = entries_reg;
        end
    end

    // Read address chosen by the sequencer; the read data is registered and is used in the next state.
    always_comb begin
        unique case (state_reg)
            ST_IDLE:  rd_addr = '0;
            ST_CK0:   rd_addr = IdxW'(n_reg - CntW'(1));
            ST_SRCH:  rd_addr = mid;
            ST_SCMP:  rd_addr = mid;
            ST_RDLO:  rd_addr = lo_reg;
            default:  rd_addr = hi_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s_entry_index] <= {s_entry_key, s_red, s_green, s_blue};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration registers.
    assign cfg_ready = (state_reg == ST_IDLE);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= CntW'(1);
            nearest_reg <= CntW'(100);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == RegEntries) entries_reg <= cfg_data;
            else                         nearest_reg <= cfg_data;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Divider operands: both positive with num < den when the divider runs.
    assign num_w = (KeyW+1)'($signed({query_reg[KeyW-1], query_reg})
                   - $signed({klo_reg[KeyW-1], klo_reg}));
    assign den_w = (KeyW+1)'($signed({khi_reg[KeyW-1], khi_reg})
                   - $signed({klo_reg[KeyW-1], klo_reg}));
    assign skip_div = ($signed(den_w) <= 0) || ($signed(num_w) <= 0)
                      || ($signed(num_w) >= $signed(den_w));

    cmap_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start_reg),
        .num    (num_w),
        .den    (den_w),
        .done   (div_done),
        .quo    (div_quo)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_cmd == CmdLookup) state_next = ST_CK0;
            ST_CK0:  state_next = (query_reg <= rd_key) ? ST_OUT : ST_CKN;
            ST_CKN:  state_next = (query_reg >= rd_key) ? ST_OUT : ST_SRCH;
            ST_SRCH: begin
                if (({1'b0, hi_reg} - {1'b0, lo_reg}) <= CntW'(1)) state_next = ST_RDLO;
                else                                              state_next = ST_SCMP;
            end
            ST_SCMP: state_next = ST_SRCH;
            ST_RDLO: state_next = ST_RDHI;
            ST_RDHI: state_next = ST_KHI;
            ST_KHI:  state_next = ST_FRAC;
            ST_FRAC: state_next = skip_div ? ST_MUL : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                query_reg <= s_query_value;
                n_reg     <= n_clamped;
                lo_reg    <= '0;
                hi_reg    <= IdxW'(n_clamped - CntW'(1));
            end
            ST_CK0: res_reg <= rd_col;
            ST_CKN: res_reg <= rd_col;
            ST_SCMP: begin
                if (query_reg >= rd_key) lo_reg <= mid;
                else                     hi_reg <= mid;
            end
            ST_RDHI: begin
                klo_reg <= rd_key;
                clo_reg <= rd_col;
            end
            ST_KHI: begin
                khi_reg <= rd_key;
                chi_reg <= rd_col;
            end
            ST_FRAC: begin
                // A fraction of zero or one needs no division.
                if ($signed(den_w) <= 0 || $signed(num_w) <= 0) begin
                    frac_reg <= '0;
                end else begin
                    frac_reg <= (FracBits+1)'(1 << FracBits);
                end
            end
            ST_DIV: if (div_done) frac_reg <= div_quo;
            ST_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    prod_lo_reg[c] <= (ChanW+FracBits+1)'(clo_reg[ChanW*(2-c) +: ChanW])
                        * (ChanW+FracBits+1)'((FracBits+1)'(1 << FracBits) - frac_reg);
                    prod_hi_reg[c] <= (ChanW+FracBits+1)'(chi_reg[ChanW*(2-c) +: ChanW])
                        * (ChanW+FracBits+1)'(frac_reg);
                end
            end
            ST_SUM: begin
                if (n_reg >= nearest_reg) begin
                    res_reg <= (frac_reg <= (FracBits+1)'(1 << (FracBits-1)))
                               ? clo_reg : chi_reg;
                end else begin
                    for (int c = 0; c < 3; c++) begin
                        res_reg[ChanW*(2-c) +: ChanW] <= ChanW'(
                            (prod_lo_reg[c] + prod_hi_reg[c]) >> FracBits);
                    end
                end
            end
            default: ;
        endcase
    end

    // Sequencer state and the divider launch pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == ST_FRAC) && !skip_div;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_col_reg <= res_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_col_reg[3*ChanW-1:2*ChanW];
    assign m_out_green = m_col_reg[2*ChanW-1:ChanW];
    assign m_out_blue  = m_col_reg[ChanW-1:0];
endmodule

@@ hdl/cmap_div_cell.sv @@
// One cell of the divider chain: a registered restoring division step.
// Depends on cmap_pkg.
module cmap_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [cmap_pkg::KeyW:0] den,
    input  cmap_pkg::div_step_t d_in,
    output cmap_pkg::div_step_t d_out
);
    import cmap_pkg::*;

    div_step_t    step_reg;
    logic [KeyW+1:0] shifted;
    logic [KeyW+1:0] diff;

    // Shift the remainder and try to subtract the divisor.
    always_comb begin
        shifted = {d_in.rem, 1'b0};
        diff    = shifted - {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg.vld <= 1'b0;
        end else begin
            step_reg.vld <= d_in.vld;
        end
        if (!diff[KeyW+1]) begin
            step_reg.rem <= diff[KeyW:0];
            step_reg.quo <= {d_in.quo[FracBits-1:0], 1'b1};
        end else begin
            step_reg.rem <= shifted[KeyW:0];
            step_reg.quo <= {d_in.quo[FracBits-1:0], 1'b0};
        end
    end

    assign d_out = step_reg;
endmodule

@@ hdl/cmap_divider.sv @@
// Chain of divider cells giving a Q0.16 fraction of num / den (num < den).
// Depends on cmap_pkg and cmap_div_cell.
module cmap_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [cmap_pkg::KeyW:0] num,
    input  logic [cmap_pkg::KeyW:0] den,
    output logic                    done,
    output logic [cmap_pkg::FracBits:0] quo
);
    import cmap_pkg::*;

    div_step_t chain [0:FracBits];

    // The first element carries the dividend; each cell adds a quotient bit.
    assign chain[0].vld = start;
    assign chain[0].rem = num;
    assign chain[0].quo = '0;

    for (genvar g = 0; g < FracBits; g++) begin : g_cell
        cmap_div_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .den    (den),
            .d_in   (chain[g]),
            .d_out  (chain[g+1])
        );
    end

    assign done = chain[FracBits].vld;
    assign quo  = chain[FracBits].quo;
endmodule

@@ sim/cmap_checker.sv @@
// Checker for the colour map lookup: watches the item, result and register
// channels, predicts each colour and compares it. Depends on cmap_pkg.
module cmap_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_cmd,
    input  logic [7:0]        s_entry_index,
    input  logic [31:0]       s_entry_key,
    input  logic [15:0]       s_red,
    input  logic [15:0]       s_green,
    input  logic [15:0]       s_blue,
    input  logic [31:0]       s_query_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [15:0]       m_out_red,
    input  logic [15:0]       m_out_green,
    input  logic [15:0]       m_out_blue,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [8:0]        cfg_data,
    output int                fail_count,
    output int                colours_pending
);
    import cmap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [KeyW-1:0] key_copy [TableDepth];
    logic [ColW-1:0]        colour_copy [TableDepth];
    logic [CntW-1:0]        used_entries;
    logic [CntW-1:0]        nearest_threshold;
    logic [ColW-1:0]        expected_colours [$];

    // Work out the colour of one query from the mirrored table.
    function automatic logic [ColW-1:0] colour_of(logic signed [KeyW-1:0] value);
        int n, lo, hi, mid, sel;
        longint num, den, frac, one, chan_lo, chan_hi;
        logic [ColW-1:0] blend;
        one = longint'(1) << FracBits;
        n = used_entries;
        if (n < 1) n = 1;
        if (n > TableDepth) n = TableDepth;
        if (value <= key_copy[0]) return colour_copy[0];
        if (value >= key_copy[n-1]) return colour_copy[n-1];
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (value >= key_copy[mid]) lo = mid;
            else hi = mid;
        end
        num = longint'(value) - longint'(key_copy[lo]);
        den = longint'(key_copy[hi]) - longint'(key_copy[lo]);
        if (den <= 0 || num <= 0) frac = 0;
        else if (num >= den) frac = one;
        else frac = (num << FracBits) / den;
        if (n >= nearest_threshold) begin
            sel = (frac <= (one >> 1)) ? lo : hi;
            return colour_copy[sel];
        end
        for (int c = 0; c < 3; c++) begin
            chan_lo = colour_copy[lo][c*ChanW +: ChanW];
            chan_hi = colour_copy[hi][c*ChanW +: ChanW];
            blend[c*ChanW +: ChanW] = ChanW'((chan_lo * (one - frac) + chan_hi * frac)
                                             >> FracBits);
        end
        return blend;
    endfunction

    task automatic report(string msg);
        $display("mismatch: %s at %0t", msg, $time);
        fail_count++;
    endtask

    assign colours_pending = expected_colours.size();

    // Mirror register writes and loads, predict lookups, check results.
    always @(posedge aclk) begin
        logic [ColW-1:0] want;
        if (!aresetn) begin
            used_entries <= 1;
            nearest_threshold <= 100;
            expected_colours.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == RegEntries) used_entries <= cfg_data;
                else nearest_threshold <= cfg_data;
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CmdLoad) begin
                    key_copy[s_entry_index] = s_entry_key;
                    colour_copy[s_entry_index] = {s_red, s_green, s_blue};
                end else begin
                    expected_colours.push_back(colour_of(s_query_value));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_colours.size() == 0) begin
                    report("unexpected colour item");
                end else begin
                    want = expected_colours.pop_front();
                    if (m_out_red !== want[47:32])
                        report($sformatf("red got %h expected %h", m_out_red, want[47:32]));
                    if (m_out_green !== want[31:16])
                        report($sformatf("green got %h expected %h",
                                         m_out_green, want[31:16]));
                    if (m_out_blue !== want[15:0])
                        report($sformatf("blue got %h expected %h", m_out_blue, want[15:0]));
                end
            end
        end
    end
endmodule

@@ sim/tb.sv @@
// Testbench top for the colour map lookup: clock, reset, stimulus and verdict.
// Depends on cmap_pkg, cmap_checker and the block itself.
module tb;
    import cmap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_cmd = 0;
    logic [7:0] s_entry_index = 0;
    logic signed [31:0] s_entry_key = 0, s_query_value = 0;
    logic [15:0] s_red = 0, s_green = 0, s_blue = 0;
    logic m_ready = 0, cfg_valid = 0, cfg_index = 0;
    logic [8:0] cfg_data = 0;
    logic s_ready, m_valid, cfg_ready;
    logic [15:0] m_out_red, m_out_green, m_out_blue;
    int fail_count, colours_pending;
    int cycle_count = 0;
    int burst_left = 0;
    logic [31:0] sorted_keys [TableDepth];

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    colour_map_interpolating_lookup u_top (.*);

    cmap_checker u_checker (.*);

    // Receiver stalls on a pattern of its own: quiet stretches and busy ones.
    always @(posedge aclk) begin
        if ((cycle_count / 700) % 3 == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("[colour_map_interpolating_lookup] ERROR");
            $finish;
        end
    end

    // Send one item; the sender may idle between bursts of random length.
    task automatic send(logic cmd, logic [7:0] index, logic [31:0] key,
                        logic [47:0] colour, logic [31:0] query);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_entry_index <= index;
        s_entry_key <= key;
        {s_red, s_green, s_blue} <= colour;
        s_query_value <= query;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load(logic [7:0] index, logic [31:0] key, logic [47:0] colour);
        send(CmdLoad, index, key, colour, $urandom);
    endtask

    task automatic lookup(logic [31:0] query);
        send(CmdLookup, 8'($urandom), $urandom, 48'({$urandom, $urandom}), query);
    endtask

    // Let every colour drain and the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colours_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Write a register once every colour is out and the block has settled.
    task automatic write_reg(logic index, logic [8:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Fill entries 0..count-1 with increasing keys spaced by random steps.
    task automatic fill_table(int count, int max_step);
        longint key;
        key = -longint'($urandom_range(0, 32'h7fff_0000));
        for (int i = 0; i < count; i++) begin
            sorted_keys[i] = 32'(key);
            load(8'(i), 32'(key), 48'({$urandom, $urandom}));
            key += $urandom_range(1, max_step);
        end
    endtask

    // Query near, between and beyond the keys of a filled table.
    function automatic logic [31:0] query_near(int count);
        int i;
        i = $urandom_range(0, count - 1);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return sorted_keys[i];
            2: return sorted_keys[i] + $urandom_range(0, 65536);
            default: return sorted_keys[i] + $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    initial begin
        int count;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single entry with default registers, then extremes.
        load(0, 32'h0, 48'hffff_0000_ffff);
        lookup(32'h8000_0000);
        lookup(32'h7fff_ffff);
        write_reg(RegEntries, 9'd0);
        lookup(32'h0000_0001);
        load(0, 32'h8000_0000, 48'h0000_0000_0000);
        load(1, 32'h7fff_ffff, 48'hffff_ffff_ffff);
        load(255, 32'h7fff_ffff, 48'h1234_5678_9abc);
        write_reg(RegEntries, 9'd2);
        lookup(32'h0000_0000);
        lookup(32'h8000_0001);
        lookup(32'h7fff_fffe);
        write_reg(RegNearest, 9'd2);
        lookup(32'h0000_0000);
        lookup(32'hffff_ffff);
        write_reg(RegNearest, 9'd0);
        lookup(32'h4000_0000);
        // Three signed keys in rising order: lookups fall in each bracketing pair.
        load(1, 32'h9000_0000, 48'h00ff_ff00_0f0f);
        write_reg(RegNearest, 9'd257);
        write_reg(RegEntries, 9'd3);
        load(2, 32'h7000_0000, 48'hf0f0_0f0f_5555);
        lookup(32'h8800_0000);
        lookup(32'h0000_0000);
        // Count above the table depth acts as a full table.
        fill_table(256, 16'hffff);
        write_reg(RegEntries, 9'd511);
        lookup(32'h7fff_ffff);
        lookup(sorted_keys[128] + 5);
        for (int k = 0; k < 20; k++) lookup(query_near(256));
        write_reg(RegNearest, 9'd100);
        for (int k = 0; k < 20; k++) lookup(query_near(256));

        // Random phases with changing sizes and thresholds.
        for (int phase = 0; phase < 6; phase++) begin
            count = $urandom_range(2, 20);
            write_reg(RegEntries, 9'(count));
            write_reg(RegNearest, (phase % 3 == 0) ? 9'd257 :
                      (phase % 3 == 1) ? 9'd1 : 9'($urandom_range(1, 40)));
            fill_table(count, (phase % 2) ? 200000 : 5000);
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 9) == 0)
                    load(8'($urandom_range(0, count - 1)), $urandom,
                         48'({$urandom, $urandom}));
                else
                    lookup(query_near(count));
            end
        end

        drain();
        if (fail_count == 0) $display("[colour_map_interpolating_lookup] OK");
        else $display("[colour_map_interpolating_lookup] ERROR");
        $finish;
    end
endmodule
